[hdl/mmts_pkg.sv]
package mmts_pkg;

  // array sizes and field widths
  localparam int MAX_MACHINES = 8;
  localparam int MAX_TASKS    = 16;
  localparam int TIME_BITS    = 16;
  localparam int MACH_W       = 3;
  localparam int TASK_W       = 4;
  localparam int FIN_W        = 24;
  localparam int MCNT_W       = 4;
  localparam int TCNT_W       = 5;
  localparam int ADDR_W       = MACH_W + TASK_W;
  localparam int MAT_DEPTH    = MAX_MACHINES * MAX_TASKS;

  localparam logic [FIN_W-1:0] FINISH_MAX = {FIN_W{1'b1}};

  // command kinds carried on in_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // configuration register indexes
  localparam logic CFG_MACHINE_COUNT = 1'b0;
  localparam logic CFG_TASK_COUNT    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } state_t;

endpackage

[hdl/mmts_ram.sv]
module mmts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/max_min_task_scheduler_core.sv]
// Max-Min task scheduler. A load word (in_tuser low) writes one execution time into the
// 8 x 16 matrix. A run word (in_tuser high) schedules task_count tasks on machine_count
// machines; no input is taken until the run has finished. Each of the task_count steps
// walks every in-use matrix entry once through the single matrix read port, and a step
// waits while the result output is stalled. One result word comes out per step; out_tlast
// marks the final one. Counts are clamped to 1..8 machines and 1..16 tasks when a run
// starts, and completion times saturate at 2^24-1.
module max_min_task_scheduler_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mmts_pkg::TCNT_W-1:0] cfg_wdata,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // machine_index[2:0], task_index[6:3],
                                                  // exec_time[22:7], zero pad
  input  logic                        in_tuser,   // command
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [71:0]                 out_tdata,  // chosen_task[3:0], chosen_machine[6:4],
                                                  // task_exec_time[22:7], finish_time[46:23],
                                                  // makespan[70:47], zero pad
  output logic                        out_tlast
);
  import mmts_pkg::*;

  state_t state_r, state_nxt;

  // configuration
  logic [MCNT_W-1:0] machine_count_r;
  logic [TCNT_W-1:0] task_count_r;
  logic [MACH_W-1:0] nm_last_r;
  logic [TASK_W-1:0] nt_last_r;

  // scheduling state
  logic [FIN_W-1:0]  ready_r [MAX_MACHINES];
  logic [MAX_TASKS-1:0] done_r;
  logic [FIN_W-1:0]  makespan_r;
  logic [TASK_W-1:0] step_r;

  // read issue counters and the tag of the read in flight
  logic [MACH_W-1:0] mi_r;
  logic [TASK_W-1:0] tj_r;
  logic              tag_vld_r;
  logic [MACH_W-1:0] tag_i_r;
  logic [TASK_W-1:0] tag_j_r;

  // per-task minimum and overall best
  logic [FIN_W-1:0]     m_fin_r;
  logic [MACH_W-1:0]    m_pos_r;
  logic [TIME_BITS-1:0] m_ex_r;
  logic                 have_r;
  logic [FIN_W-1:0]     best_fin_r;
  logic [MACH_W-1:0]    best_mach_r;
  logic [TASK_W-1:0]    best_task_r;
  logic [TIME_BITS-1:0] best_ex_r;

  // output register
  logic              out_vld_r;
  logic [71:0]       out_data_r;
  logic              out_last_r;

  logic                 in_acc, run_acc, load_acc;
  logic                 issue, scan_end, emit_go, last_step;
  logic [ADDR_W-1:0]    raddr;
  logic [TIME_BITS-1:0] rdata;
  logic [FIN_W:0]       sum;
  logic [FIN_W-1:0]     f;
  logic                 take_f;
  logic [FIN_W-1:0]     cand_fin;
  logic [MACH_W-1:0]    cand_pos;
  logic [TIME_BITS-1:0] cand_ex;
  logic                 take_best;
  logic [FIN_W-1:0]     span_new;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign run_acc   = in_acc && (in_tuser == CMD_RUN);
  assign load_acc  = in_acc && (in_tuser == CMD_LOAD);

  assign issue     = (state_r == ST_SCAN);
  assign scan_end  = issue && (mi_r == nm_last_r) && (tj_r == nt_last_r);
  assign emit_go   = (state_r == ST_EMIT) && (!out_vld_r || out_tready);
  assign last_step = (step_r == nt_last_r);
  assign raddr     = {mi_r, tj_r};

  // execution-time matrix
  mmts_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAT_DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (load_acc),
    .waddr ({in_tdata[2:0], in_tdata[6:3]}),
    .wdata (in_tdata[22:7]),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared saturating add and compare unit
  always_comb begin
    sum      = {1'b0, ready_r[tag_i_r]} + {{(FIN_W + 1 - TIME_BITS){1'b0}}, rdata};
    f        = sum[FIN_W] ? FINISH_MAX : sum[FIN_W-1:0];
    take_f   = (tag_i_r == '0) || (f < m_fin_r);
    cand_fin = take_f ? f : m_fin_r;
    cand_pos = take_f ? tag_i_r : m_pos_r;
    cand_ex  = take_f ? rdata : m_ex_r;
    take_best = tag_vld_r && (tag_i_r == nm_last_r) && !done_r[tag_j_r] &&
                (!have_r || (cand_fin > best_fin_r));
    span_new = (best_fin_r > makespan_r) ? best_fin_r : makespan_r;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (run_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = last_step ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machine_count_r <= MCNT_W'(MAX_MACHINES);
      task_count_r    <= TCNT_W'(MAX_TASKS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MACHINE_COUNT: machine_count_r <= cfg_wdata[MCNT_W-1:0];
        CFG_TASK_COUNT:    task_count_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // run control, read issue and tag stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r  <= 1'b0;
      done_r     <= '0;
      makespan_r <= '0;
      have_r     <= 1'b0;
      step_r     <= '0;
      mi_r       <= '0;
      tj_r       <= '0;
      nm_last_r  <= MACH_W'(MAX_MACHINES - 1);
      nt_last_r  <= TASK_W'(MAX_TASKS - 1);
      for (int m = 0; m < MAX_MACHINES; m++) begin
        ready_r[m] <= '0;
      end
    end else begin
      tag_vld_r <= issue;
      tag_i_r   <= mi_r;
      tag_j_r   <= tj_r;

      // run start: clamp counts and clear run state
      if (run_acc) begin
        if (machine_count_r == '0) begin
          nm_last_r <= '0;
        end else if (machine_count_r > MCNT_W'(MAX_MACHINES)) begin
          nm_last_r <= MACH_W'(MAX_MACHINES - 1);
        end else begin
          nm_last_r <= MACH_W'(machine_count_r - 1'b1);
        end
        if (task_count_r == '0) begin
          nt_last_r <= '0;
        end else if (task_count_r > TCNT_W'(MAX_TASKS)) begin
          nt_last_r <= TASK_W'(MAX_TASKS - 1);
        end else begin
          nt_last_r <= TASK_W'(task_count_r - 1'b1);
        end
        done_r     <= '0;
        makespan_r <= '0;
        have_r     <= 1'b0;
        step_r     <= '0;
        mi_r       <= '0;
        tj_r       <= '0;
        for (int m = 0; m < MAX_MACHINES; m++) begin
          ready_r[m] <= '0;
        end
      end

      // walk machines inside tasks
      if (issue) begin
        if (mi_r == nm_last_r) begin
          mi_r <= '0;
          tj_r <= tj_r + 1'b1;
        end else begin
          mi_r <= mi_r + 1'b1;
        end
      end

      // per-task minimum over machines
      if (tag_vld_r) begin
        m_fin_r <= cand_fin;
        m_pos_r <= cand_pos;
        m_ex_r  <= cand_ex;
      end

      // largest minimum over tasks
      if (take_best) begin
        have_r      <= 1'b1;
        best_fin_r  <= cand_fin;
        best_mach_r <= cand_pos;
        best_task_r <= tag_j_r;
        best_ex_r   <= cand_ex;
      end

      // commit the chosen task and start the next step
      if (emit_go) begin
        ready_r[best_mach_r] <= best_fin_r;
        done_r[best_task_r]  <= 1'b1;
        makespan_r           <= span_new;
        step_r               <= step_r + 1'b1;
        have_r               <= 1'b0;
        mi_r                 <= '0;
        tj_r                 <= '0;
      end
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r <= {1'b0, span_new, best_fin_r, best_ex_r, best_mach_r, best_task_r};
      out_last_r <= last_step;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // a run start closes the input until the run is over
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    run_acc |=> !in_tready)
    else $error("input taken right after a run start");

  // reads are only in flight while scanning
  a_tag_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_vld_r |-> (state_r == ST_SCAN || state_r == ST_WAIT))
    else $error("matrix read outside a scan");

  // running makespan never below the reported finish time
  a_span_covers_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r[70:47] >= out_data_r[46:23]))
    else $error("makespan below finish time");

  // a result is only committed with a best candidate found
  a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> have_r)
    else $error("result committed without a candidate");

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmts_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_WORDS = 100;

  // one stimulus word: a matrix load or a schedule run
  typedef struct {
    logic                 cmd;
    logic [MACH_W-1:0]    mach;
    logic [TASK_W-1:0]    tsk_idx;
    logic [TIME_BITS-1:0] etime;
  } sched_word_t;

  // one predicted placement
  typedef struct {
    logic [TASK_W-1:0]    task_id;
    logic [MACH_W-1:0]    mach_id;
    logic [TIME_BITS-1:0] exec_t;
    logic [FIN_W-1:0]     finish;
    logic [FIN_W-1:0]     span;
    logic                 last;
  } sched_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = 1'b0;
  logic [TCNT_W-1:0] cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [71:0]       out_tdata;
  logic              out_tlast;

  // stimulus side
  sched_word_t word_q[$];
  bit          loaded [MAX_MACHINES][MAX_TASKS];
  int          words_queued = 0;
  bit          in_fire = 1'b0;
  int          gap_left = 0;
  int          burst_left = 0;

  // receiver side
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_tick = 0;
  int       rx_hold = 0;

  // scheduler model
  logic [TIME_BITS-1:0] exec_mat [MAX_MACHINES][MAX_TASKS];
  logic [MCNT_W-1:0]    mach_cfg = 4'd8;
  logic [TCNT_W-1:0]    task_cfg = 5'd16;
  sched_result_t        expect_q[$];

  int fail_count  = 0;
  int cycle_count = 0;
  int n_loads     = 0;
  int n_runs      = 0;
  int n_results   = 0;

  max_min_task_scheduler_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [FIN_W-1:0] sat_sum(logic [FIN_W-1:0] a, logic [TIME_BITS-1:0] b);
    logic [FIN_W:0] s;
    s = a + b;
    return (s > FINISH_MAX) ? FINISH_MAX : s[FIN_W-1:0];
  endfunction

  // max-min placement of every task in use, one expectation per step
  function automatic void schedule_run();
    int                nm, nt, mpos, btask, bmach;
    logic [FIN_W-1:0]  ready [MAX_MACHINES];
    bit                done [MAX_TASKS];
    logic [FIN_W-1:0]  span, f, mfin, bfin;
    bit                have;
    sched_result_t     r;
    nm = clamp_count(int'(mach_cfg), MAX_MACHINES);
    nt = clamp_count(int'(task_cfg), MAX_TASKS);
    foreach (ready[i]) ready[i] = '0;
    foreach (done[j]) done[j] = 1'b0;
    span = '0;
    for (int k = 0; k < nt; k++) begin
      have  = 1'b0;
      btask = 0;
      bmach = 0;
      bfin  = '0;
      for (int j = 0; j < nt; j++) begin
        if (!done[j]) begin
          // least completion time over machines, first machine on ties
          mpos = 0;
          mfin = '0;
          for (int i = 0; i < nm; i++) begin
            f = sat_sum(ready[i], exec_mat[i][j]);
            if (i == 0 || f < mfin) begin
              mfin = f;
              mpos = i;
            end
          end
          // largest of the minima, first task on ties
          if (!have || mfin > bfin) begin
            have  = 1'b1;
            bfin  = mfin;
            btask = j;
            bmach = mpos;
          end
        end
      end
      done[btask]  = 1'b1;
      ready[bmach] = bfin;
      if (bfin > span) span = bfin;
      r.task_id = TASK_W'(btask);
      r.mach_id = MACH_W'(bmach);
      r.exec_t  = exec_mat[bmach][btask];
      r.finish  = bfin;
      r.span    = span;
      r.last    = (k == nt - 1);
      expect_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [FIN_W-1:0] want, logic [FIN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return TIME_BITS'($urandom_range(0, 3));
    if (r < 7) return TIME_BITS'($urandom_range(0, 255));
    return TIME_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic void push_load(int m, int t, logic [TIME_BITS-1:0] etime);
    sched_word_t w;
    w.cmd     = CMD_LOAD;
    w.mach    = MACH_W'(m);
    w.tsk_idx = TASK_W'(t);
    w.etime   = etime;
    loaded[m][t] = 1'b1;
    word_q.push_back(w);
    words_queued++;
  endfunction

  // a run word carries random bits in its unused fields
  function automatic void push_run();
    sched_word_t w;
    w.cmd     = CMD_RUN;
    w.mach    = MACH_W'($urandom);
    w.tsk_idx = TASK_W'($urandom);
    w.etime   = TIME_BITS'($urandom);
    word_q.push_back(w);
    words_queued++;
  endfunction

  // every entry a run will read gets written first
  function automatic void fill_in_use(int nm, int nt);
    for (int m = 0; m < nm; m++)
      for (int t = 0; t < nt; t++)
        if (!loaded[m][t]) push_load(m, t, rand_time());
  endfunction

  // raw count value, mostly small, sometimes zero or beyond the range
  function automatic logic [TCNT_W-1:0] pick_count(int hi);
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return TCNT_W'($urandom_range(1, (hi + 1) / 2));
    if (r < 12) return TCNT_W'($urandom_range((hi + 1) / 2, hi));
    if (r == 12) return '0;
    return TCNT_W'($urandom_range(hi + 1, 31));
  endfunction

  task automatic write_reg(logic idx, logic [TCNT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_counts(logic [TCNT_W-1:0] mc, logic [TCNT_W-1:0] tc);
    write_reg(CFG_MACHINE_COUNT, mc);
    write_reg(CFG_TASK_COUNT, tc);
  endtask

  // every queued word taken and every expected result seen
  task automatic wait_drained();
    do @(negedge clk);
    while (n_loads + n_runs != words_queued || expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // input driver: bursts of words separated by random gaps
  always @(negedge clk) begin
    sched_word_t w;
    if (!rst_n || (in_tvalid && !in_fire)) begin
      // hold the current word until it is taken
    end else if (gap_left > 0) begin
      gap_left  <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (word_q.size() > 0) begin
      w = word_q.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= w.cmd;
      in_tdata  <= {1'b0, w.etime, w.tsk_idx, w.mach};
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result receiver: open, random or long stalls, mode changes now and then
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 48 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
    case (rx_mode)
      RX_OPEN: out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 9) < 6);
      default: begin
        if (rx_hold > 0) begin
          rx_hold    <= rx_hold - 1;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          rx_hold    <= $urandom_range(1, 12);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // monitor: register writes, accepted words, result words
  always @(posedge clk) begin
    sched_result_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_MACHINE_COUNT) mach_cfg = cfg_wdata[MCNT_W-1:0];
        else task_cfg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_LOAD) begin
          exec_mat[in_tdata[2:0]][in_tdata[6:3]] = in_tdata[22:7];
          n_loads++;
        end else begin
          schedule_run();
          n_runs++;
        end
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (expect_q.size() == 0) begin
          $display("%0t: result word with nothing expected, data %h last %b",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = expect_q.pop_front();
          check_field("chosen_task", FIN_W'(want.task_id), FIN_W'(out_tdata[3:0]));
          check_field("chosen_machine", FIN_W'(want.mach_id), FIN_W'(out_tdata[6:4]));
          check_field("task_exec_time", FIN_W'(want.exec_t), FIN_W'(out_tdata[22:7]));
          check_field("finish_time", want.finish, out_tdata[46:23]);
          check_field("makespan", want.span, out_tdata[70:47]);
          check_field("last", FIN_W'(want.last), FIN_W'(out_tlast));
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("max_min_task_scheduler_core: mismatch");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [TCNT_W-1:0] mc, tc;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    // single task on a single machine, longest time; a far entry overwritten
    set_counts(5'd1, 5'd1);
    push_load(0, 0, 16'hFFFF);
    push_load(MAX_MACHINES - 1, MAX_TASKS - 1, 16'h5A5A);
    push_load(MAX_MACHINES - 1, MAX_TASKS - 1, 16'hA5A5);
    push_run();
    wait_drained();

    // ties on machine and on task, a zero time, two runs back to back
    set_counts(5'd2, 5'd3);
    push_load(0, 0, 16'd5);
    push_load(1, 0, 16'd5);
    push_load(0, 1, 16'd0);
    push_load(1, 1, 16'd3);
    push_load(0, 2, 16'd5);
    push_load(1, 2, 16'd7);
    push_run();
    push_run();
    wait_drained();

    // zero counts clamp to one
    set_counts(5'd0, 5'd0);
    push_run();
    wait_drained();

    // random phases, mostly small sizes
    while (words_queued < RANDOM_WORDS) begin
      mc = pick_count(MAX_MACHINES);
      tc = pick_count(MAX_TASKS);
      set_counts(mc, tc);
      fill_in_use(clamp_count(int'(mc[MCNT_W-1:0]), MAX_MACHINES),
                  clamp_count(int'(tc), MAX_TASKS));
      repeat ($urandom_range(0, 4))
        push_load($urandom_range(0, MAX_MACHINES - 1), $urandom_range(0, MAX_TASKS - 1),
                  rand_time());
      push_run();
      if ($urandom_range(0, 3) == 0) push_run();
      wait_drained();
    end

    // oversized counts clamp to the full matrix
    set_counts(5'd15, 5'd31);
    fill_in_use(MAX_MACHINES, MAX_TASKS);
    push_run();
    wait_drained();

    // full matrix at its exact limits
    set_counts(TCNT_W'(MAX_MACHINES), TCNT_W'(MAX_TASKS));
    push_load(MAX_MACHINES - 1, MAX_TASKS - 1, 16'hFFFF);
    push_load(0, MAX_TASKS - 1, 16'h0000);
    push_run();
    wait_drained();

    $display("covered %0d matrix loads and %0d schedule runs, %0d result words checked",
             n_loads, n_runs, n_results);
    if (fail_count == 0) begin
      $display("max_min_task_scheduler_core: match");
    end else begin
      $display("max_min_task_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule
